/* src/apn_pkg.sv */
// Shared types and constants for the audio peak normalizer.
package apn_pkg;

    // Meaning of the command flag carried in the input tuser.
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_SCALE   = 1'b1;

    // Bit positions in the input tuser.
    localparam int TUSER_CMD_BIT   = 0;
    localparam int TUSER_START_BIT = 1;
    localparam int IN_TUSER_W      = 2;

    // Gain register.
    localparam int         GAIN_BITS  = 8;
    localparam logic [7:0] GAIN_RESET = 8'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic measure;    // fold the incoming sample into the peak
        logic load_scale; // capture the incoming sample for scaling
        logic mul_full;   // magnitude times full scale
        logic mul_gain;   // times gain, and load the divider
        logic div_step;   // one quotient bit
        logic out_load;   // move the finished result to the output register
    } apn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;   // the current divider step is the last one
        logic out_free;   // the output register can take a result this cycle
    } apn_sts_t;

endpackage

/* src/apn_ctrl.sv */
// Controller state machine of the audio peak normalizer.
module apn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_command,
    output logic             in_ready,
    input  apn_pkg::apn_sts_t sts,
    output apn_pkg::apn_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FULL,
        ST_MUL_GAIN,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   in_fire;

    assign in_fire  = in_valid && ready_reg;
    assign in_ready = ready_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_command == apn_pkg::CMD_SCALE)
                    begin
                        cmd.load_scale = 1'b1;
                        state_next     = ST_MUL_FULL;
                        ready_next     = 1'b0;
                    end
                    else
                    begin
                        cmd.measure = 1'b1;
                    end
                end
            end
            ST_MUL_FULL:
            begin
                cmd.mul_full = 1'b1;
                state_next   = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                    ready_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

/* src/apn_datapath.sv */
// Datapath of the audio peak normalizer: peak, gain, multipliers, divider, output.
module apn_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  apn_pkg::apn_cmd_t      cmd,
    output apn_pkg::apn_sts_t      sts,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_start,
    input  logic                   cfg_we,
    input  logic [apn_pkg::GAIN_BITS-1:0] cfg_gain,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   out_sat
);

    localparam int B      = SAMPLE_BITS;
    localparam int PROD_W = 2 * B - 2;
    localparam int NUM_W  = PROD_W + apn_pkg::GAIN_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic [B-1:0]     FULL      = {1'b0, {(B-1){1'b1}}};
    localparam logic [B-1:0]     LIMIT_NEG = {1'b1, {(B-1){1'b0}}};
    localparam logic [CNT_W-1:0] STEPS     = CNT_W'(NUM_W);

    logic [apn_pkg::GAIN_BITS-1:0] gain_reg;
    logic [B-1:0]       peak_reg, peak_next;
    logic [B-1:0]       mag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [B-1:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic [B-1:0]       out_sample_reg;
    logic               out_sat_reg;

    logic [B-1:0]       in_mag;
    logic [2*B-1:0]     prod_wide;
    logic [NUM_W-1:0]   num_wide;
    logic [B:0]         rem_shift;
    logic               take;
    logic [B-1:0]       limit;
    logic               over;
    logic               peak_zero;
    logic [B-1:0]       res_mag;
    logic [B-1:0]       res_value;
    logic               res_sat;

    // Magnitude of the incoming sample; the most negative code maps to 2^(B-1).
    assign in_mag = in_sample[B-1] ? (~in_sample + 1'b1) : in_sample;

    // Peak update for a measure item.
    always_comb
    begin
        peak_next = in_start ? '0 : peak_reg;
        if (in_mag > peak_next)
        begin
            peak_next = in_mag;
        end
    end

    // Products: magnitude times full scale, then times gain.
    assign prod_wide = mag_reg * FULL;
    assign num_wide  = NUM_W'(prod_reg) * NUM_W'(gain_reg);

    // One restoring division step of the numerator by the peak.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign take      = rem_shift >= {1'b0, peak_reg};
    assign rem_next  = take ? (rem_shift[B-1:0] - peak_reg) : rem_shift[B-1:0];
    assign quo_next  = {quo_reg[NUM_W-2:0], take};

    // Saturation and sign of the finished quotient.
    assign peak_zero = peak_reg == '0;
    assign limit     = neg_reg ? LIMIT_NEG : FULL;
    assign over      = quo_reg > {{(NUM_W-B){1'b0}}, limit};
    assign res_sat   = !peak_zero && over;
    always_comb
    begin
        if (peak_zero)
        begin
            res_mag = '0;
        end
        else if (over)
        begin
            res_mag = limit;
        end
        else
        begin
            res_mag = quo_reg[B-1:0];
        end
    end
    assign res_value = neg_reg ? (~res_mag + 1'b1) : res_mag;

    // Control state: gain, peak, step counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= apn_pkg::GAIN_RESET;
            peak_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_gain;
            end
            if (cmd.measure)
            begin
                peak_reg <= peak_next;
            end
            if (cmd.mul_gain)
            begin
                cnt_reg <= STEPS;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of one scale item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_scale)
        begin
            mag_reg <= in_mag;
            neg_reg <= in_sample[B-1];
        end
        if (cmd.mul_full)
        begin
            prod_reg <= prod_wide[PROD_W-1:0];
        end
        if (cmd.mul_gain)
        begin
            quo_reg <= num_wide;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= res_value;
            out_sat_reg    <= res_sat;
        end
    end

    assign sts.div_last = cnt_reg == CNT_W'(1);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_sat    = out_sat_reg;

endmodule

/* src/audio_peak_normalizer_top.sv */
// Top level of the audio peak normalizer.
//
//  Channel  Direction  Handshake                    Contents
//  s_*      in         s_tvalid / s_tready          tdata: sample; tuser: command, start_req
//  m_*      out        m_tvalid / m_tready          tdata: scaled_sample; tuser: saturated
//  cfg_*    in         cfg_valid / cfg_ready        cfg_data: gain
//
// A measure item updates the peak at its accepting edge.
// A scale item holds off further items from acceptance until its result is loaded
// into the output register, passing the two multiplies and the restoring divider that
// yields one quotient bit per cycle over the 2*SAMPLE_BITS+6 bit numerator.
// A result waits in the output register while the next items are accepted;
// only a second finished result stalls until that register is taken.
// Reset sets gain to 1, clears the peak and empties the output register.
module audio_peak_normalizer_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // Input items.
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample, zero padding
    input  logic [apn_pkg::IN_TUSER_W-1:0]   s_tuser, // command, start_req
    // Result items.
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // scaled_sample, zero padding
    output logic [0:0]                       m_tuser, // saturated
    // Gain register write.
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [apn_pkg::GAIN_BITS-1:0]    cfg_data
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    apn_pkg::apn_cmd_t      cmd;
    apn_pkg::apn_sts_t      sts;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic                   out_sat;

    assign cfg_ready = 1'b1;

    apn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser[apn_pkg::TUSER_CMD_BIT]),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    apn_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_start   (s_tuser[apn_pkg::TUSER_START_BIT]),
        .cfg_we     (cfg_valid),
        .cfg_gain   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_sample (out_sample),
        .out_sat    (out_sat)
    );

    // Pack the result item.
    assign m_tdata    = DATA_W'(out_sample);
    assign m_tuser[0] = out_sat;

endmodule

/* src/apn_checker.sv */
// Port-level assertions for the audio peak normalizer, bound to the top level.
module apn_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic [apn_pkg::IN_TUSER_W-1:0]   s_tuser,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input logic [0:0]                       m_tuser,
    input logic cfg_valid,
    input logic cfg_ready
);

    localparam logic [SAMPLE_BITS-1:0] POS_FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic scale_fire;
    logic measure_fire;

    assign scale_fire   = s_tvalid && s_tready &&
                          s_tuser[apn_pkg::TUSER_CMD_BIT] == apn_pkg::CMD_SCALE;
    assign measure_fire = s_tvalid && s_tready &&
                          s_tuser[apn_pkg::TUSER_CMD_BIT] == apn_pkg::CMD_MEASURE;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A saturated result sits at one of the two range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[SAMPLE_BITS-1:0] == POS_FULL || m_tdata[SAMPLE_BITS-1:0] == NEG_FULL))
        else $error("saturated result is not at a range limit");

    // A scale item occupies the block: no item is taken in the next cycle.
    a_scale_busy: assert property (@(posedge clk) disable iff (!rst_n)
        scale_fire |=> !s_tready)
        else $error("input accepted right after a scale item");

    // A measure item never produces a result.
    a_measure_silent: assert property (@(posedge clk) disable iff (!rst_n)
        measure_fire && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a measure item");

    // The gain register never stalls a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind audio_peak_normalizer_top apn_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_apn_checker (.*);
